[hw/rtl/iirtf_pkg.sv]
// Shared types and constants for the third-order IIR trajectory filter.
// Holds the tap geometry, field widths, register indexes and the command
// and status structs between the controller and the datapath.
`timescale 1ns / 1ps

package iirtf_pkg;

  localparam int TAPS      = 4;
  localparam int NTAPS     = (TAPS < 4) ? TAPS : 4;
  localparam int HIST      = NTAPS - 1;
  localparam int NUM_TERMS = 2 * HIST + 1;
  localparam int TERM_W    = (NUM_TERMS > 2) ? $clog2(NUM_TERMS) : 1;
  localparam int HIDX_W    = (HIST > 1) ? $clog2(HIST) : 1;

  localparam int NUM_COEF  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int COEF_W    = 48;
  localparam int SAMPLE_W  = 32;
  localparam int YHIST_W   = 64;
  localparam int VEL_W     = 48;
  localparam int ACCUM_W   = 128;

  localparam int DERIV_SCALE = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_B3,
    REG_A1,
    REG_A2,
    REG_A3
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic              mul_en;
    logic [TERM_W-1:0] term;
    logic [1:0]        part;
    logic              round;
    logic              pos_en;
    logic              vel_en;
    logic              acc_en;
    logic              commit;
  } iirtf_cmd_t;

  typedef struct packed {
    logic out_free;
  } iirtf_status_t;

endpackage

[hw/rtl/iirtf_ctrl.sv]
// Sequencer for the IIR trajectory filter.
// Walks the multiply-accumulate terms one partial product at a time, then
// the rounding and derivative steps. Depends on iirtf_pkg.
`timescale 1ns / 1ps

module iirtf_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  iirtf_pkg::iirtf_status_t status,
  output iirtf_pkg::iirtf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_POS,
    S_VEL,
    S_ACC,
    S_COMMIT
  } state_t;

  state_t                          state;
  logic [iirtf_pkg::TERM_W-1:0]    term;
  logic [1:0]                      part;

  localparam logic [iirtf_pkg::TERM_W-1:0] LAST_TERM =
    iirtf_pkg::TERM_W'(iirtf_pkg::NUM_TERMS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term  <= '0;
      part  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          term <= '0;
          part <= '0;
          if (in_valid) begin
            state <= S_MAC;
          end
        end
        S_MAC: begin
          part <= part + 2'd1;
          if (part == 2'd3) begin
            term <= term + iirtf_pkg::TERM_W'(1);
            if (term == LAST_TERM) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN:  state <= S_ROUND;
        S_ROUND:  state <= S_POS;
        S_POS:    state <= S_VEL;
        S_VEL:    state <= S_ACC;
        S_ACC:    state <= S_COMMIT;
        S_COMMIT: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.term   = term;
    cmd.part   = part;
    cmd.start  = (state == S_IDLE) && in_valid;
    cmd.mul_en = (state == S_MAC);
    cmd.round  = (state == S_ROUND);
    cmd.pos_en = (state == S_POS);
    cmd.vel_en = (state == S_VEL);
    cmd.acc_en = (state == S_ACC);
    cmd.commit = (state == S_COMMIT) && status.out_free;
  end

endmodule

[hw/rtl/iirtf_dp.sv]
// Datapath of the IIR trajectory filter: coefficient registers, histories,
// a shared 33x33 partial-product multiplier with a 128-bit accumulator,
// rounding, derivative units and the output register. Depends on iirtf_pkg.
`timescale 1ns / 1ps

module iirtf_dp (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [iirtf_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [iirtf_pkg::COEF_W-1:0]                 cfg_data,
  input  logic signed [iirtf_pkg::SAMPLE_W-1:0]        step_sample,
  input  iirtf_pkg::iirtf_cmd_t                        cmd,
  output iirtf_pkg::iirtf_status_t                     status,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic signed [iirtf_pkg::SAMPLE_W-1:0]        position,
  output logic signed [iirtf_pkg::VEL_W-1:0]           velocity,
  output logic signed [iirtf_pkg::VEL_W-1:0]           acceleration
);

  logic signed [iirtf_pkg::COEF_W-1:0]   coef   [iirtf_pkg::NUM_COEF];
  logic signed [iirtf_pkg::SAMPLE_W-1:0] xhist  [iirtf_pkg::HIST];
  logic signed [iirtf_pkg::YHIST_W-1:0]  yhist  [iirtf_pkg::HIST];
  logic signed [iirtf_pkg::SAMPLE_W-1:0] x_cur;
  logic signed [iirtf_pkg::SAMPLE_W-1:0] prev_pos;
  logic signed [iirtf_pkg::VEL_W-1:0]    prev_vel;

  logic signed [65:0]                    prod;
  logic [1:0]                            prod_part;
  logic                                  prod_valid;
  logic signed [iirtf_pkg::ACCUM_W-1:0]  accum;

  logic signed [iirtf_pkg::YHIST_W-1:0]  y_new;
  logic signed [iirtf_pkg::SAMPLE_W-1:0] pos_new;
  logic signed [iirtf_pkg::VEL_W-1:0]    vel_new;
  logic signed [iirtf_pkg::VEL_W-1:0]    acc_new;

  // Operand selection for the current term.
  logic                                  fb;
  logic [iirtf_pkg::CFG_IDX_W-1:0]       a_idx;
  logic [iirtf_pkg::HIDX_W-1:0]          hx;
  logic [iirtf_pkg::HIDX_W-1:0]          hy;
  logic signed [iirtf_pkg::COEF_W-1:0]   craw;
  logic signed [iirtf_pkg::COEF_W:0]     c49;
  logic signed [iirtf_pkg::YHIST_W-1:0]  dsel;
  logic signed [iirtf_pkg::SAMPLE_W-1:0] xsel;
  logic signed [32:0]                    ca;
  logic signed [32:0]                    da;

  always_comb begin
    fb    = cmd.term > iirtf_pkg::TERM_W'(iirtf_pkg::HIST);
    a_idx = iirtf_pkg::CFG_IDX_W'(iirtf_pkg::REG_A1)
          + iirtf_pkg::CFG_IDX_W'(cmd.term - iirtf_pkg::TERM_W'(iirtf_pkg::HIST + 1));
    hx    = iirtf_pkg::HIDX_W'(cmd.term - iirtf_pkg::TERM_W'(1));
    hy    = iirtf_pkg::HIDX_W'(cmd.term - iirtf_pkg::TERM_W'(iirtf_pkg::HIST + 1));
    craw  = fb ? coef[a_idx] : coef[iirtf_pkg::CFG_IDX_W'(cmd.term)];
    c49   = fb ? -{craw[iirtf_pkg::COEF_W-1], craw} : {craw[iirtf_pkg::COEF_W-1], craw};
    xsel  = (cmd.term == '0) ? x_cur : xhist[hx];
    // Feedforward samples enter pre-scaled by 2^24 so every term has 92 fraction bits.
    dsel  = fb ? yhist[hy] : {{8{xsel[iirtf_pkg::SAMPLE_W-1]}}, xsel, 24'd0};
    ca    = cmd.part[0] ? {{16{c49[48]}}, c49[48:32]} : {1'b0, c49[31:0]};
    da    = cmd.part[1] ? {dsel[63], dsel[63:32]}     : {1'b0, dsel[31:0]};
  end

  // Accumulator input, aligned by the chunk weights.
  logic signed [iirtf_pkg::ACCUM_W-1:0] pp_ext;
  logic [6:0]                           pp_shift;

  always_comb begin
    pp_shift = (7'(prod_part[0]) + 7'(prod_part[1])) << 5;
    pp_ext   = {{(iirtf_pkg::ACCUM_W - 66){prod[65]}}, prod} <<< pp_shift;
  end

  // Round half up to 48 fraction bits and saturate to 64 bits.
  logic signed [iirtf_pkg::ACCUM_W-1:0] rnd;
  logic signed [83:0]                   rsh;
  logic signed [iirtf_pkg::YHIST_W-1:0] y_rnd;

  always_comb begin
    rnd = accum + (iirtf_pkg::ACCUM_W'(1) << 43);
    rsh = rnd[127:44];
    if (rsh[83:63] == '0 || rsh[83:63] == '1) begin
      y_rnd = rsh[63:0];
    end else if (rsh[83]) begin
      y_rnd = {1'b1, 63'd0};
    end else begin
      y_rnd = {1'b0, {63{1'b1}}};
    end
  end

  // Position, velocity and acceleration arithmetic.
  logic signed [40:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic signed [32:0] pdiff;
  logic signed [43:0] vprod;
  logic signed [48:0] vdiff;
  logic signed [59:0] aprod;
  logic signed [47:0] acc_sat;

  always_comb begin
    pos_sum = {y_new[63], y_new[63:24]} + 41'(y_new[23]);
    if (pos_sum[40:31] == '0 || pos_sum[40:31] == '1) begin
      pos_sat = pos_sum[31:0];
    end else if (pos_sum[40]) begin
      pos_sat = {1'b1, 31'd0};
    end else begin
      pos_sat = {1'b0, {31{1'b1}}};
    end
    pdiff = 33'(pos_new) - 33'(prev_pos);
    vprod = 44'(pdiff) * 44'(iirtf_pkg::DERIV_SCALE);
    vdiff = 49'(vel_new) - 49'(prev_vel);
    aprod = 60'(vdiff) * 60'(iirtf_pkg::DERIV_SCALE);
    if (aprod[59:47] == '0 || aprod[59:47] == '1) begin
      acc_sat = aprod[47:0];
    end else if (aprod[59]) begin
      acc_sat = {1'b1, 47'd0};
    end else begin
      acc_sat = {1'b0, {47{1'b1}}};
    end
  end

  assign status.out_free = !out_valid || out_ready;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_cur <= step_sample;
    end
    if (cmd.mul_en) begin
      prod      <= ca * da;
      prod_part <= cmd.part;
    end
    if (cmd.start) begin
      accum <= '0;
    end else if (prod_valid) begin
      accum <= accum + pp_ext;
    end
    if (cmd.round) begin
      y_new <= y_rnd;
    end
    if (cmd.pos_en) begin
      pos_new <= pos_sat;
    end
    if (cmd.vel_en) begin
      vel_new <= 48'(vprod);
    end
    if (cmd.acc_en) begin
      acc_new <= acc_sat;
    end
    if (cmd.commit) begin
      position     <= pos_new;
      velocity     <= vel_new;
      acceleration <= acc_new;
    end
  end

  // Filter state, coefficients and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < iirtf_pkg::NUM_COEF; i++) begin
        coef[i] <= '0;
      end
      for (int i = 0; i < iirtf_pkg::HIST; i++) begin
        xhist[i] <= '0;
        yhist[i] <= '0;
      end
      prev_pos   <= '0;
      prev_vel   <= '0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= cmd.mul_en;
      if (cfg_we && cfg_index <= iirtf_pkg::REG_A3) begin
        coef[cfg_index] <= cfg_data;
      end
      if (cmd.commit) begin
        for (int i = iirtf_pkg::HIST - 1; i > 0; i--) begin
          xhist[i] <= xhist[i-1];
          yhist[i] <= yhist[i-1];
        end
        xhist[0]  <= x_cur;
        yhist[0]  <= y_new;
        prev_pos  <= pos_new;
        prev_vel  <= vel_new;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/iir_trajectory_filter_with_derivatives.sv]
// Third-order IIR trajectory filter with velocity and acceleration outputs.
// Samples are filtered one at a time, the rate being set by the single
// shared 33x33 multiplier that takes four partial products for each of the
// seven filter terms; a new sample is accepted only after the last is committed.
// Reset (synchronous, active high) clears coefficients, histories, the
// previous position and velocity, and any pending result.
`timescale 1ns / 1ps

module iir_trajectory_filter_with_derivatives (
  input  logic                                  clk,
  input  logic                                  rst,
  // Coefficient write channel. Index 0..6 selects b0..b3, a1..a3; index 7 is ignored.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [iirtf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [iirtf_pkg::COEF_W-1:0]          cfg_data,
  // Step command samples, Q8.24.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [iirtf_pkg::SAMPLE_W-1:0] step_sample,
  // Filtered position (Q8.24) with its derivatives (Q24.24).
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [iirtf_pkg::SAMPLE_W-1:0] position,
  output logic signed [iirtf_pkg::VEL_W-1:0]    velocity,
  output logic signed [iirtf_pkg::VEL_W-1:0]    acceleration
);

  iirtf_pkg::iirtf_cmd_t    cmd;
  iirtf_pkg::iirtf_status_t status;

  // Coefficients are taken on any cycle; they must only change while the
  // filter is idle.
  assign cfg_ready = 1'b1;

  // The controller accepts a sample only when idle. It sequences the
  // multiply-accumulate over every term, one 33x33 partial product per
  // cycle, then rounding, position, velocity and acceleration, and finally
  // commits the result into the output register once that register is free.
  // A finished result can sit in the output register while the next sample
  // is accepted and processed.
  iirtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the coefficient registers, the input and output
  // histories, the 128-bit exact accumulator and the output register.
  iirtf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step_sample  (step_sample),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .position     (position),
    .velocity     (velocity),
    .acceleration (acceleration)
  );

endmodule
